### rtl/bf_program_executor_top_defines.svh
// assertion macros used by the executor sequencer (bfpe_ctrl)
// expects clk and rst_n in the scope of each use
`ifndef BF_PROGRAM_EXECUTOR_TOP_DEFINES_SVH
`define BF_PROGRAM_EXECUTOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define BFPE_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bfpe assertion failed");
`define BFPE_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bfpe forbidden condition seen");
`else
`define BFPE_ASSERT(name, prop)
`define BFPE_NEVER(name, cond)
`endif
`endif

### rtl/bfpe_pkg.sv
// types and constants of the program executor
// used by the sequencer, the result stage and the top level
package bfpe_pkg;

  // instruction characters
  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  localparam int unsigned SLICE_W = 16;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_CONT  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_LOADED = 3'd0,
    KIND_OUTPUT = 3'd1,
    KIND_INPUT  = 3'd2,
    KIND_HALTED = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_HEAD_LOW  = 3'd1,
    ERR_TAPE_OVF  = 3'd2,
    ERR_NEG_OUT   = 3'd3,
    ERR_UNMATCHED = 3'd4,
    ERR_UNKNOWN   = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    RUN_IDLE   = 2'd0,
    RUN_PAUSED = 2'd1,
    RUN_HALTED = 2'd2,
    RUN_ERROR  = 2'd3
  } run_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_FETCH,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EMIT
  } state_t;

  // one result beat, kind in the lowest bits
  typedef struct packed {
    err_t        err;
    logic [7:0]  ch;
    kind_t       kind;
  } result_t;

  function automatic result_t make_res(kind_t k, logic [7:0] c, err_t e);
    result_t r;
    r.kind = k;
    r.ch   = c;
    r.err  = e;
    return r;
  endfunction

endpackage

### rtl/bf_program_executor_top.sv
// Program executor for the eight-instruction tape language. A load beat
// writes one program byte and answers at once. A start beat zeroes the
// tape, one cell per cycle, then runs; a continue beat resumes a paused
// run. Each run beat ends on an output, an input request, a halt, an
// error, or after 65536 instructions. Every instruction is a program and
// tape memory read, then execute and write back; an open bracket, and a
// close bracket on a nonzero cell, add a read and a check per program
// byte scanned, since the match is found by walking the single program
// memory read port with a depth count.
// One beat is taken at a time; the next may be taken while a result waits.
// top level: instantiates bfpe_ctrl, bfpe_out_stage and two bfpe_ram
module bf_program_executor_top #(
  parameter int PROG_DEPTH = 4096,
  parameter int TAPE_DEPTH = 1024,
  parameter int CELL_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // mode[1:0], address[13:2], program_byte[21:14],
                                  // input_value[53:22], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // kind[2:0], out_char[10:3], error_code[13:11], zero fill
);
  import bfpe_pkg::*;

  localparam int PW = $clog2(PROG_DEPTH);
  localparam int HW = $clog2(TAPE_DEPTH);

  logic                  res_valid, res_ready;
  result_t               res, out_res;
  logic                  prog_we;
  logic [PW-1:0]         prog_waddr, prog_raddr;
  logic [7:0]            prog_wdata, prog_rdata;
  logic                  tape_we;
  logic [HW-1:0]         tape_waddr, tape_raddr;
  logic [CELL_WIDTH-1:0] tape_wdata, tape_rdata;

  bfpe_ctrl #(
    .PROG_DEPTH (PROG_DEPTH),
    .TAPE_DEPTH (TAPE_DEPTH),
    .CELL_WIDTH (CELL_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_mode         (mode_t'(in_tdata[1:0])),
    .in_address      (in_tdata[13:2]),
    .in_program_byte (in_tdata[21:14]),
    .in_input_value  (in_tdata[53:22]),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .prog_we         (prog_we),
    .prog_waddr      (prog_waddr),
    .prog_wdata      (prog_wdata),
    .prog_raddr      (prog_raddr),
    .prog_rdata      (prog_rdata),
    .tape_we         (tape_we),
    .tape_waddr      (tape_waddr),
    .tape_wdata      (tape_wdata),
    .tape_raddr      (tape_raddr),
    .tape_rdata      (tape_rdata)
  );

  // program memory
  bfpe_ram #(
    .WIDTH (8),
    .DEPTH (PROG_DEPTH)
  ) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (prog_wdata),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  // tape memory
  bfpe_ram #(
    .WIDTH (CELL_WIDTH),
    .DEPTH (TAPE_DEPTH)
  ) u_tape_ram (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (tape_raddr),
    .rdata (tape_rdata)
  );

  bfpe_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {2'b00, out_res};

endmodule

### rtl/bfpe_ram.sv
// generic ram, one write port and one read port, registered read
// no dependencies
module bfpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bfpe_ctrl.sv
// sequencer: decodes items, steps the program, scans brackets, clears the tape
// depends on bfpe_pkg and the assertion macro header
`include "bf_program_executor_top_defines.svh"
module bfpe_ctrl #(
  parameter int PROG_DEPTH = 4096,
  parameter int TAPE_DEPTH = 1024,
  parameter int CELL_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bfpe_pkg::mode_t               in_mode,
  input  logic [11:0]                   in_address,
  input  logic [7:0]                    in_program_byte,
  input  logic [31:0]                   in_input_value,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bfpe_pkg::result_t             res,
  output logic                          prog_we,
  output logic [$clog2(PROG_DEPTH)-1:0] prog_waddr,
  output logic [7:0]                    prog_wdata,
  output logic [$clog2(PROG_DEPTH)-1:0] prog_raddr,
  input  logic [7:0]                    prog_rdata,
  output logic                          tape_we,
  output logic [$clog2(TAPE_DEPTH)-1:0] tape_waddr,
  output logic [CELL_WIDTH-1:0]         tape_wdata,
  output logic [$clog2(TAPE_DEPTH)-1:0] tape_raddr,
  input  logic [CELL_WIDTH-1:0]         tape_rdata
);
  import bfpe_pkg::*;

  localparam int PW  = $clog2(PROG_DEPTH);
  localparam int PAW = $clog2(PROG_DEPTH + 1);
  localparam int HW  = $clog2(TAPE_DEPTH);

  state_t             state_r, state_nxt;
  run_status_t        status_r, status_nxt;
  logic               pend_r, pend_nxt;
  logic [PAW-1:0]     pc_r, pc_nxt;
  logic [HW-1:0]      head_r, head_nxt;
  logic [PAW-1:0]     idx_r, idx_nxt;
  logic [PAW-1:0]     depth_r, depth_nxt;
  logic [HW-1:0]      clr_r, clr_nxt;
  logic [SLICE_W-1:0] cnt_r, cnt_nxt;
  logic               fwd_r, fwd_nxt;
  logic               oob_r, oob_nxt;
  logic [CELL_WIDTH-1:0] cell_r, cell_nxt;
  result_t            res_r, res_nxt;
  logic               do_step;
  logic [PAW-1:0]     pc_inc, idx_dec;

  assign pc_inc  = pc_r + PAW'(1);
  assign idx_dec = idx_r - PAW'(1);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= RUN_IDLE;
      pend_r   <= 1'b0;
      pc_r     <= '0;
      head_r   <= '0;
      depth_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      pend_r   <= pend_nxt;
      pc_r     <= pc_nxt;
      head_r   <= head_nxt;
      depth_r  <= depth_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    clr_r  <= clr_nxt;
    cnt_r  <= cnt_nxt;
    fwd_r  <= fwd_nxt;
    oob_r  <= oob_nxt;
    cell_r <= cell_nxt;
    res_r  <= res_nxt;
  end

  assign res = res_r;

  // next state and memory accesses
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    pend_nxt   = pend_r;
    pc_nxt     = pc_r;
    head_nxt   = head_r;
    idx_nxt    = idx_r;
    depth_nxt  = depth_r;
    clr_nxt    = clr_r;
    cnt_nxt    = cnt_r;
    fwd_nxt    = fwd_r;
    oob_nxt    = oob_r;
    cell_nxt   = cell_r;
    res_nxt    = res_r;
    do_step    = 1'b0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    prog_we    = 1'b0;
    prog_waddr = PW'(in_address);
    prog_wdata = in_program_byte;
    prog_raddr = pc_r[PW-1:0];
    tape_we    = 1'b0;
    tape_waddr = head_r;
    tape_wdata = cell_r + CELL_WIDTH'(1);
    tape_raddr = head_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_mode)
            MODE_LOAD: begin
              prog_we   = (32'(in_address) < PROG_DEPTH);
              res_nxt   = make_res(KIND_LOADED, 8'd0, ERR_NONE);
              state_nxt = S_EMIT;
            end
            MODE_START: begin
              pc_nxt     = '0;
              head_nxt   = '0;
              depth_nxt  = '0;
              pend_nxt   = 1'b0;
              status_nxt = RUN_PAUSED;
              cnt_nxt    = '0;
              clr_nxt    = '0;
              state_nxt  = S_CLEAR;
            end
            MODE_CONT: begin
              if (status_r != RUN_PAUSED) begin
                res_nxt   = make_res(KIND_HALTED, 8'd0, ERR_NONE);
                state_nxt = S_EMIT;
              end else begin
                cnt_nxt   = '0;
                state_nxt = S_FETCH;
                if (pend_r) begin
                  tape_we    = 1'b1;
                  tape_wdata = in_input_value[CELL_WIDTH-1:0];
                  pend_nxt   = 1'b0;
                  pc_nxt     = pc_inc;
                end
              end
            end
            default: begin
              res_nxt   = make_res(KIND_LOADED, 8'd0, ERR_NONE);
              state_nxt = S_EMIT;
            end
          endcase
        end
      end

      // zero the tape, one cell a cycle
      S_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_r;
        tape_wdata = '0;
        clr_nxt    = clr_r + HW'(1);
        if (clr_r == HW'(TAPE_DEPTH - 1)) begin
          state_nxt = S_FETCH;
        end
      end

      // read opcode and current cell
      S_FETCH: begin
        oob_nxt   = (pc_r >= PAW'(PROG_DEPTH));
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        cell_nxt = tape_rdata;
        if (oob_r || prog_rdata == CH_END) begin
          status_nxt = RUN_HALTED;
          res_nxt    = make_res(KIND_HALTED, 8'd0, ERR_NONE);
          state_nxt  = S_EMIT;
        end else begin
          priority case (prog_rdata)
            CH_RIGHT: begin
              if (head_r == HW'(TAPE_DEPTH - 1)) begin
                status_nxt = RUN_ERROR;
                res_nxt    = make_res(KIND_ERROR, 8'd0, ERR_TAPE_OVF);
                state_nxt  = S_EMIT;
              end else begin
                head_nxt = head_r + HW'(1);
                pc_nxt   = pc_inc;
                do_step  = 1'b1;
              end
            end
            CH_LEFT: begin
              if (head_r == '0) begin
                status_nxt = RUN_ERROR;
                res_nxt    = make_res(KIND_ERROR, 8'd0, ERR_HEAD_LOW);
                state_nxt  = S_EMIT;
              end else begin
                head_nxt = head_r - HW'(1);
                pc_nxt   = pc_inc;
                do_step  = 1'b1;
              end
            end
            CH_INC: begin
              tape_we    = 1'b1;
              tape_wdata = tape_rdata + CELL_WIDTH'(1);
              pc_nxt     = pc_inc;
              do_step    = 1'b1;
            end
            CH_DEC: begin
              tape_we    = 1'b1;
              tape_wdata = tape_rdata - CELL_WIDTH'(1);
              pc_nxt     = pc_inc;
              do_step    = 1'b1;
            end
            CH_IN: begin
              pend_nxt  = 1'b1;
              res_nxt   = make_res(KIND_INPUT, 8'd0, ERR_NONE);
              state_nxt = S_EMIT;
            end
            CH_OUT: begin
              if (tape_rdata[CELL_WIDTH-1]) begin
                status_nxt = RUN_ERROR;
                res_nxt    = make_res(KIND_ERROR, 8'd0, ERR_NEG_OUT);
              end else begin
                pc_nxt  = pc_inc;
                res_nxt = make_res(KIND_OUTPUT, tape_rdata[7:0], ERR_NONE);
              end
              state_nxt = S_EMIT;
            end
            CH_OPEN: begin
              fwd_nxt   = 1'b1;
              idx_nxt   = pc_inc;
              depth_nxt = '0;
              state_nxt = S_SCAN_RD;
            end
            CH_CLOSE: begin
              if (tape_rdata != '0) begin
                fwd_nxt   = 1'b0;
                idx_nxt   = pc_r;
                depth_nxt = '0;
                state_nxt = S_SCAN_RD;
              end else begin
                pc_nxt  = pc_inc;
                do_step = 1'b1;
              end
            end
            default: begin
              status_nxt = RUN_ERROR;
              res_nxt    = make_res(KIND_ERROR, 8'd0, ERR_UNKNOWN);
              state_nxt  = S_EMIT;
            end
          endcase
        end
      end

      // issue the read of the next scanned byte
      S_SCAN_RD: begin
        if (fwd_r) begin
          prog_raddr = idx_r[PW-1:0];
          if (idx_r >= PAW'(PROG_DEPTH)) begin
            status_nxt = RUN_ERROR;
            res_nxt    = make_res(KIND_ERROR, 8'd0, ERR_UNMATCHED);
            state_nxt  = S_EMIT;
          end else begin
            state_nxt = S_SCAN_CHK;
          end
        end else begin
          prog_raddr = idx_dec[PW-1:0];
          if (idx_r == '0) begin
            status_nxt = RUN_ERROR;
            res_nxt    = make_res(KIND_ERROR, 8'd0, ERR_UNMATCHED);
            state_nxt  = S_EMIT;
          end else begin
            idx_nxt   = idx_dec;
            state_nxt = S_SCAN_CHK;
          end
        end
      end

      // track nesting depth on the scanned byte
      S_SCAN_CHK: begin
        state_nxt = S_SCAN_RD;
        if (fwd_r) begin
          idx_nxt = idx_r + PAW'(1);
          if (prog_rdata == CH_END) begin
            status_nxt = RUN_ERROR;
            res_nxt    = make_res(KIND_ERROR, 8'd0, ERR_UNMATCHED);
            state_nxt  = S_EMIT;
          end else if (prog_rdata == CH_OPEN) begin
            depth_nxt = depth_r + PAW'(1);
          end else if (prog_rdata == CH_CLOSE) begin
            if (depth_r == '0) begin
              pc_nxt    = (cell_r == '0) ? idx_r + PAW'(1) : pc_inc;
              state_nxt = S_FETCH;
              do_step   = 1'b1;
            end else begin
              depth_nxt = depth_r - PAW'(1);
            end
          end
        end else begin
          if (prog_rdata == CH_CLOSE) begin
            depth_nxt = depth_r + PAW'(1);
          end else if (prog_rdata == CH_OPEN) begin
            if (depth_r == '0) begin
              pc_nxt    = idx_r + PAW'(1);
              state_nxt = S_FETCH;
              do_step   = 1'b1;
            end else begin
              depth_nxt = depth_r - PAW'(1);
            end
          end
        end
      end

      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // instruction done without an event: next fetch or slice end
    if (do_step) begin
      depth_nxt = '0;
      if (cnt_r == '1) begin
        res_nxt   = make_res(KIND_LOADED, 8'd0, ERR_NONE);
        state_nxt = S_EMIT;
      end else begin
        cnt_nxt   = cnt_r + SLICE_W'(1);
        state_nxt = S_FETCH;
      end
    end
  end

  `BFPE_ASSERT(a_err_code, res_valid && res.kind == KIND_ERROR |-> res.err != ERR_NONE)
  `BFPE_ASSERT(a_char_only_out, res_valid && res.kind != KIND_OUTPUT |-> res.ch == 8'd0)
  `BFPE_ASSERT(a_pend_paused, pend_r |-> status_r == RUN_PAUSED)
  `BFPE_NEVER(a_pc_bound, pc_r > PAW'(PROG_DEPTH))

endmodule

### rtl/bfpe_out_stage.sv
// result register between the sequencer and the result channel
// depends on bfpe_pkg
module bfpe_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  bfpe_pkg::result_t res,
  output logic              out_tvalid,
  input  logic              out_tready,
  output bfpe_pkg::result_t out_res
);
  import bfpe_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign res_ready  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = data_r;

  // hold one beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res;
    end
  end

endmodule

### bench/tb_bf_program_executor_top.sv
// self-checking bench for bf_program_executor_top: a scoreboard class predicts
// each result from the accepted input beats; depends on bfpe_pkg and the rtl
module tb_bf_program_executor_top;
  import bfpe_pkg::*;

  localparam int PROG_N = 4096;
  localparam int TAPE_N = 1024;
  localparam int SLICE_N = 65536;
  localparam int CYCLE_LIMIT = 50000000;

  // executor predictor and store of expected result beats
  class exec_scoreboard;
    logic [7:0]  pmem [PROG_N];
    logic [31:0] tape [TAPE_N];
    int unsigned head, pc;
    bit          want_input;
    run_status_t status;
    result_t     awaited [$];
    int          mismatches, checked, n_out, n_inp, n_halt, n_err, n_slice;

    function new();
      head = 0; pc = 0; want_input = 0; status = RUN_IDLE;
    endfunction

    function result_t fail(err_t e);
      status = RUN_ERROR;
      return make_res(KIND_ERROR, 8'h00, e);
    endfunction

    // execute until an event or the end of the time slice
    function result_t run_slice();
      logic [7:0]  op;
      logic [31:0] c;
      int unsigned i, depth;
      bit          found;
      for (int n = 0; n < SLICE_N; n++) begin
        op = (pc < PROG_N) ? pmem[pc] : CH_END;
        if (op == CH_END) begin
          status = RUN_HALTED;
          return make_res(KIND_HALTED, 8'h00, ERR_NONE);
        end
        c = tape[head];
        case (op)
          CH_RIGHT: begin
            if (head + 1 >= TAPE_N) return fail(ERR_TAPE_OVF);
            head++; pc++;
          end
          CH_LEFT: begin
            if (head == 0) return fail(ERR_HEAD_LOW);
            head--; pc++;
          end
          CH_INC: begin tape[head] = c + 1; pc++; end
          CH_DEC: begin tape[head] = c - 1; pc++; end
          CH_IN: begin
            want_input = 1; status = RUN_PAUSED;
            return make_res(KIND_INPUT, 8'h00, ERR_NONE);
          end
          CH_OUT: begin
            if (c[31]) return fail(ERR_NEG_OUT);
            pc++; status = RUN_PAUSED;
            return make_res(KIND_OUTPUT, c[7:0], ERR_NONE);
          end
          CH_OPEN: begin
            i = pc + 1; found = 0; depth = 0;
            while (i < PROG_N && pmem[i] != CH_END) begin
              if (pmem[i] == CH_OPEN) depth++;
              else if (pmem[i] == CH_CLOSE) begin
                if (depth == 0) begin found = 1; break; end
                depth--;
              end
              i++;
            end
            if (!found) return fail(ERR_UNMATCHED);
            pc = (c == 0) ? i + 1 : pc + 1;
          end
          CH_CLOSE: begin
            if (c != 0) begin
              i = pc; found = 0; depth = 0;
              while (i > 0) begin
                i--;
                if (pmem[i] == CH_CLOSE) depth++;
                else if (pmem[i] == CH_OPEN) begin
                  if (depth == 0) begin found = 1; break; end
                  depth--;
                end
              end
              if (!found) return fail(ERR_UNMATCHED);
              pc = i + 1;
            end else pc++;
          end
          default: return fail(ERR_UNKNOWN);
        endcase
      end
      status = RUN_PAUSED;
      return make_res(KIND_LOADED, 8'h00, ERR_NONE);
    endfunction

    // note one accepted input beat and queue its expected result
    function void note_item(logic [1:0] m, logic [11:0] a, logic [7:0] b, logic [31:0] v);
      result_t r;
      r = make_res(KIND_LOADED, 8'h00, ERR_NONE);
      if (m == MODE_LOAD) pmem[a] = b;
      else if (m == MODE_START) begin
        foreach (tape[k]) tape[k] = '0;
        head = 0; pc = 0; want_input = 0; status = RUN_PAUSED;
        r = run_slice();
      end else if (m == MODE_CONT) begin
        if (status != RUN_PAUSED) r = make_res(KIND_HALTED, 8'h00, ERR_NONE);
        else begin
          if (want_input) begin
            tape[head] = v; want_input = 0; pc++;
          end
          r = run_slice();
        end
      end
      if (m != MODE_LOAD && r.kind == KIND_LOADED && m != 2'd3) n_slice++;
      awaited.push_back(r);
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_result(logic [15:0] d);
      result_t e;
      checked++;
      if (awaited.size() == 0) begin
        $error("result beat with no expectation: %h", d);
        mismatches++;
        return;
      end
      e = awaited.pop_front();
      if (d[2:0] !== e.kind) begin
        $error("kind: expected %0d actual %0d", e.kind, d[2:0]); mismatches++;
      end
      if (d[10:3] !== e.ch) begin
        $error("out_char: expected %0d actual %0d", e.ch, d[10:3]); mismatches++;
      end
      if (d[13:11] !== e.err) begin
        $error("error_code: expected %0d actual %0d", e.err, d[13:11]); mismatches++;
      end
      if (d[15:14] !== 2'b00) begin
        $error("zero fill: expected 0 actual %0d", d[15:14]); mismatches++;
      end
      case (e.kind)
        KIND_OUTPUT: n_out++;
        KIND_INPUT:  n_inp++;
        KIND_HALTED: n_halt++;
        KIND_ERROR:  n_err++;
        default: ;
      endcase
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, out_tvalid, out_tready;
  logic [55:0] in_tdata;
  logic [15:0] out_tdata;
  int          cycles, items;
  bit          in_calm, out_calm;
  exec_scoreboard sb;

  bf_program_executor_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // clock and cycle limit
  initial begin
    clk = 0;
    forever begin
      #5 clk = ~clk;
      if (clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
          $display("timeout after %0d cycles", cycles);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // drive one input beat and wait for its handshake
  task automatic send(logic [1:0] m, logic [31:0] a, logic [31:0] b, logic [31:0] v);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, v, b[7:0], a[11:0], m};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(m, a[11:0], b[7:0], v);
    items++;
    if (items % 60 == 0) in_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic load_text(string s);
    for (int i = 0; i < s.len(); i++) send(MODE_LOAD, i, 32'(s[i]), $urandom);
    send(MODE_LOAD, s.len(), 32'(CH_END), $urandom);
  endtask

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return -$urandom_range(1, 300);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // start the loaded program and keep resuming it while it pauses
  task automatic run_program(int max_resumes);
    int n;
    n = 0;
    send(MODE_START, $urandom, $urandom, $urandom);
    while (sb.status == RUN_PAUSED && n < max_resumes) begin
      if ($urandom_range(0, 9) == 0)
        send(MODE_LOAD, $urandom_range(3000, 3999), $urandom, $urandom);
      send(MODE_CONT, $urandom, $urandom, draw_value());
      n++;
    end
  endtask

  // random program: loops of bounded count, or input and noise without loops
  task automatic random_program();
    string s;
    int    k;
    s = "";
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 4)) begin
        k = $urandom_range(0, 5);
        repeat (k) s = {s, "+"};
        s = {s, "[>"};
        repeat ($urandom_range(1, 3)) s = {s, "+"};
        if ($urandom_range(0, 1)) s = {s, "."};
        s = {s, "<-]>"};
        if ($urandom_range(0, 1)) s = {s, "."};
      end
    end else begin
      repeat ($urandom_range(1, 20)) begin
        case ($urandom_range(0, 15))
          0, 1, 2: s = {s, "+"};
          3, 4:    s = {s, "-"};
          5, 6:    s = {s, ">"};
          7:       s = {s, "<"};
          8, 9, 10: s = {s, "."};
          11, 12:  s = {s, ","};
          13:      s = {s, string'(8'($urandom_range(1, 255)))};
          default: s = {s, "+"};
        endcase
      end
      if ($urandom_range(0, 5) == 0) s = {s, ($urandom_range(0, 1) ? "[" : "]"), "."};
    end
    load_text(s);
    if ($urandom_range(0, 9) == 0) send(2'd3, $urandom, $urandom, $urandom);
    run_program(40);
    if ($urandom_range(0, 7) == 0) send(MODE_CONT, $urandom, $urandom, $urandom);
  endtask

  // result side: random stalls, every accepted beat checked
  initial begin
    int gap, seen;
    out_tready = 1'b0;
    seen = 0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata);
      seen++;
      if (seen % 50 == 0) out_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // stimulus and end of run
  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_calm = 0;
    out_calm = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle continue, unknown mode, each error and event
    send(MODE_CONT, 32'hFFF, 32'hFF, 32'hFFFF_FFFF);
    send(2'd3, 32'hABC, 32'h5A, 32'h8000_0000);
    load_text("+.>+++.");          run_program(4);
    load_text("<");                run_program(1);
    load_text("-.");               run_program(1);
    load_text("+[");               run_program(1);
    load_text("+]");               run_program(1);
    load_text("].");               run_program(2);
    load_text("[+].");             run_program(2);
    load_text("+q");               run_program(1);
    load_text(",.,.");             run_program(0);
    send(MODE_CONT, 0, 0, 32'h0000_0041);
    send(MODE_CONT, 0, 0, 32'h7FFF_FFFF);
    send(MODE_CONT, 0, 0, 32'h8000_0000);
    load_text("+[>+]");            run_program(1);
    load_text("+[]");              run_program(0);

    // random programs
    while (items < 2000) random_program();
    in_tvalid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d input beats, %0d results checked", items, sb.checked);
    $display("outputs %0d, input requests %0d, halts %0d, errors %0d, slices %0d",
             sb.n_out, sb.n_inp, sb.n_halt, sb.n_err, sb.n_slice);
    if (sb.mismatches == 0 && sb.awaited.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
